FILE: sv/lbmq5_pkg.sv
package lbmq5_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REST_FRACTION   = 3'd0,
    CFG_RELAX_RATE      = 3'd1,
    CFG_VELOCITY_WEIGHT = 3'd2,
    CFG_INLET_CONC      = 3'd3,
    CFG_OUTLET_CONC     = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    EDGE_INTERIOR = 2'd0,
    EDGE_INLET    = 2'd1,
    EDGE_OUTLET   = 2'd2
  } edge_kind_t;

  typedef struct packed {
    logic valid;
    logic wall;
  } ctl_t;

endpackage

FILE: sv/lbmq5_cfg.sv
module lbmq5_cfg #(
  parameter int FRAC_BITS = lbmq5_pkg::FRAC_BITS_DEF,
  localparam int RW = FRAC_BITS + 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [lbmq5_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [RW-1:0]                         cfg_data,
  output logic [RW-1:0]                         rest_fraction,
  output logic [RW-1:0]                         relax_rate,
  output logic [RW-1:0]                         velocity_weight,
  output logic [RW-1:0]                         inlet_conc,
  output logic [RW-1:0]                         outlet_conc
);
  import lbmq5_pkg::*;

  localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
  // 0.2, 1/1.5, 0.5 and 1.0 in Q1.F, rounded
  localparam logic [RW-1:0] REST_RST  = RW'((2 * ONE_L + 5) / 10);
  localparam logic [RW-1:0] RELAX_RST = RW'((4 * ONE_L + 3) / 6);
  localparam logic [RW-1:0] VW_RST    = RW'(ONE_L / 2);
  localparam logic [RW-1:0] IN_RST    = RW'(ONE_L);
  localparam logic [RW-1:0] OUT_RST   = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_fraction   <= REST_RST;
      relax_rate      <= RELAX_RST;
      velocity_weight <= VW_RST;
      inlet_conc      <= IN_RST;
      outlet_conc     <= OUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_REST_FRACTION:   rest_fraction   <= cfg_data;
        CFG_RELAX_RATE:      relax_rate      <= cfg_data;
        CFG_VELOCITY_WEIGHT: velocity_weight <= cfg_data;
        CFG_INLET_CONC:      inlet_conc      <= cfg_data;
        CFG_OUTLET_CONC:     outlet_conc     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/lbmq5_front.sv
module lbmq5_front #(
  parameter int FRAC_BITS = lbmq5_pkg::FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 2,
  localparam int RW = FRAC_BITS + 1,
  localparam int PW = 2 * VW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lbmq5_pkg::ctl_t       in_ctl,
  input  logic signed [VW-1:0]  dist_in [5],
  input  logic signed [VW-1:0]  vel_x,
  input  logic signed [VW-1:0]  vel_y,
  input  logic [1:0]            edge_kind,
  input  logic [RW-1:0]         rest_fraction,
  input  logic [RW-1:0]         velocity_weight,
  input  logic [RW-1:0]         inlet_conc,
  input  logic [RW-1:0]         outlet_conc,
  output lbmq5_pkg::ctl_t       out_ctl,
  output logic signed [VW-1:0]  g_out [5],
  output logic signed [VW-1:0]  conc_out,
  output logic signed [VW-1:0]  coef_out [4],
  output logic signed [PW-1:0]  prod_rest_out
);
  import lbmq5_pkg::*;

  localparam int SW = PW + 2;
  localparam int AW = VW + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic [RW-1:0] ONE_R = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] x);
    logic signed [VW-1:0] r;
    if (&x[SW-1:VW-1] || ~|x[SW-1:VW-1]) r = x[VW-1:0];
    else if (x[SW-1]) r = {1'b1, {(VW-1){1'b0}}};
    else r = {1'b0, {(VW-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  // stage 1: edge correction, concentration, velocity projections
  logic signed [AW-1:0] sum_all, sum_in, sum_out;
  logic signed [VW-1:0] g_fix [5];
  logic signed [VW-1:0] conc_fix;
  logic signed [PW-1:0] px_next, py_next;

  always_comb begin
    sum_all = AW'(dist_in[0]) + AW'(dist_in[1]) + AW'(dist_in[2]) + AW'(dist_in[3])
              + AW'(dist_in[4]);
    sum_in  = AW'($signed({1'b0, inlet_conc})) - AW'(dist_in[0]) - AW'(dist_in[2])
              - AW'(dist_in[3]) - AW'(dist_in[4]);
    sum_out = AW'($signed({1'b0, outlet_conc})) - AW'(dist_in[0]) - AW'(dist_in[1])
              - AW'(dist_in[2]) - AW'(dist_in[4]);
    for (int k = 0; k < 5; k++) g_fix[k] = dist_in[k];
    conc_fix = sat_v(SW'(sum_all));
    if (!in_ctl.wall) begin
      case (edge_kind)
        EDGE_INLET: begin
          g_fix[1] = sat_v(SW'(sum_in));
          conc_fix = $signed({1'b0, inlet_conc});
        end
        EDGE_OUTLET: begin
          g_fix[3] = sat_v(SW'(sum_out));
          conc_fix = $signed({1'b0, outlet_conc});
        end
        default: ;
      endcase
    end
  end

  assign px_next = $signed({1'b0, velocity_weight}) * vel_x;
  assign py_next = $signed({1'b0, velocity_weight}) * vel_y;

  ctl_t                 s1_ctl;
  logic signed [VW-1:0] s1_g [5];
  logic signed [VW-1:0] s1_conc;
  logic signed [PW-1:0] s1_px, s1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_g    <= g_fix;
    s1_conc <= conc_fix;
    s1_px   <= px_next;
    s1_py   <= py_next;
  end

  // stage 2: direction coefficients, rest equilibrium product
  logic signed [VW-1:0] base;
  logic signed [SW-1:0] base_sh;
  logic signed [SW-1:0] c2 [4];
  logic signed [VW-1:0] coef_next [4];
  logic signed [PW-1:0] prod_rest_next;

  always_comb begin
    base    = $signed({1'b0, ONE_R}) - $signed({1'b0, rest_fraction});
    base_sh = SW'(base) <<< (FRAC_BITS - 2);
    c2[0]   = base_sh + SW'(s1_px);
    c2[1]   = base_sh + SW'(s1_py);
    c2[2]   = base_sh - SW'(s1_px);
    c2[3]   = base_sh - SW'(s1_py);
    for (int k = 0; k < 4; k++) coef_next[k] = sat_v(rnd(c2[k]));
  end

  assign prod_rest_next = s1_conc * $signed({1'b0, rest_fraction});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    g_out         <= s1_g;
    conc_out      <= s1_conc;
    coef_out      <= coef_next;
    prod_rest_out <= prod_rest_next;
  end

endmodule

FILE: sv/lbmq5_collide.sv
module lbmq5_collide #(
  parameter int FRAC_BITS = lbmq5_pkg::FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 2,
  localparam int RW = FRAC_BITS + 1,
  localparam int PW = 2 * VW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lbmq5_pkg::ctl_t       in_ctl,
  input  logic signed [VW-1:0]  g_in [5],
  input  logic signed [VW-1:0]  conc_in,
  input  logic signed [VW-1:0]  coef_in [4],
  input  logic signed [PW-1:0]  prod_rest_in,
  input  logic [RW-1:0]         relax_rate,
  output logic                  done,
  output logic signed [VW-1:0]  conc_out,
  output logic signed [VW-1:0]  post_out [5]
);
  import lbmq5_pkg::*;

  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] x);
    logic signed [VW-1:0] r;
    if (&x[SW-1:VW-1] || ~|x[SW-1:VW-1]) r = x[VW-1:0];
    else if (x[SW-1]) r = {1'b1, {(VW-1){1'b0}}};
    else r = {1'b0, {(VW-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  // stage 3: equilibrium products
  ctl_t                 s3_ctl;
  logic signed [VW-1:0] s3_g [5];
  logic signed [VW-1:0] s3_conc;
  logic signed [PW-1:0] s3_prod [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else begin
      s3_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s3_g       <= g_in;
    s3_conc    <= conc_in;
    s3_prod[0] <= prod_rest_in;
    for (int k = 0; k < 4; k++) s3_prod[k+1] <= conc_in * coef_in[k];
  end

  // stage 4: round equilibria, distance from equilibrium
  logic signed [VW-1:0] eq [5];
  logic signed [VW-1:0] diff_next [5];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      eq[k]        = sat_v(rnd(SW'(s3_prod[k])));
      diff_next[k] = sat_v(SW'(s3_g[k]) - SW'(eq[k]));
    end
  end

  ctl_t                 s4_ctl;
  logic signed [VW-1:0] s4_g [5];
  logic signed [VW-1:0] s4_conc;
  logic signed [VW-1:0] s4_diff [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl <= '0;
    end else begin
      s4_ctl <= s3_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s4_g    <= s3_g;
    s4_conc <= s3_conc;
    s4_diff <= diff_next;
  end

  // stage 5: relaxation products
  ctl_t                 s5_ctl;
  logic signed [VW-1:0] s5_g [5];
  logic signed [VW-1:0] s5_conc;
  logic signed [PW-1:0] s5_prod [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl <= '0;
    end else begin
      s5_ctl <= s4_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s5_g    <= s4_g;
    s5_conc <= s4_conc;
    for (int k = 0; k < 5; k++) s5_prod[k] <= $signed({1'b0, relax_rate}) * s4_diff[k];
  end

  // stage 6: relax, or bounce back on a wall
  logic signed [VW-1:0] post_next [5];
  logic signed [VW-1:0] conc_next;

  always_comb begin
    for (int k = 0; k < 5; k++) post_next[k] = sat_v(SW'(s5_g[k]) - rnd(SW'(s5_prod[k])));
    conc_next = s5_conc;
    if (s5_ctl.wall) begin
      conc_next    = '0;
      post_next[0] = '0;
      post_next[1] = s5_g[3];
      post_next[2] = s5_g[4];
      post_next[3] = s5_g[1];
      post_next[4] = s5_g[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    conc_out <= conc_next;
    post_out <= post_next;
  end

endmodule

FILE: sv/lbm_d2q5_cell_update_top.sv
// throughput: one beat per cycle, busy stays low out of reset
// six register stages: correction, coefficients, equilibrium multiply,
// difference, relaxation multiply, output register
// synchronous reset clears the pipeline valid bits and loads register defaults
// results cannot be stalled, each beat shows on done for one cycle
module lbm_d2q5_cell_update_top #(
  parameter int FRAC_BITS = lbmq5_pkg::FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 2,
  localparam int RW = FRAC_BITS + 1,
  localparam int PW = 2 * VW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VW-1:0]               dist_rest,
  input  logic signed [VW-1:0]               dist_east,
  input  logic signed [VW-1:0]               dist_north,
  input  logic signed [VW-1:0]               dist_west,
  input  logic signed [VW-1:0]               dist_south,
  input  logic                               is_wall,
  input  logic signed [VW-1:0]               vel_x,
  input  logic signed [VW-1:0]               vel_y,
  input  logic [1:0]                         edge_kind,
  input  logic                               cfg_wr_en,
  input  logic [lbmq5_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [RW-1:0]                      cfg_data,
  output logic                               done,
  output logic signed [VW-1:0]               conc,
  output logic signed [VW-1:0]               post_rest,
  output logic signed [VW-1:0]               post_east,
  output logic signed [VW-1:0]               post_north,
  output logic signed [VW-1:0]               post_west,
  output logic signed [VW-1:0]               post_south
);
  import lbmq5_pkg::*;

  logic [RW-1:0] rest_fraction, relax_rate, velocity_weight, inlet_conc, outlet_conc;

  lbmq5_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rest_fraction   (rest_fraction),
    .relax_rate      (relax_rate),
    .velocity_weight (velocity_weight),
    .inlet_conc      (inlet_conc),
    .outlet_conc     (outlet_conc)
  );

  assign busy = rst;

  ctl_t                 in_ctl;
  logic signed [VW-1:0] dist_in [5];

  assign in_ctl.valid = start && !busy;
  assign in_ctl.wall  = is_wall;
  assign dist_in[0] = dist_rest;
  assign dist_in[1] = dist_east;
  assign dist_in[2] = dist_north;
  assign dist_in[3] = dist_west;
  assign dist_in[4] = dist_south;

  ctl_t                 fr_ctl;
  logic signed [VW-1:0] fr_g [5];
  logic signed [VW-1:0] fr_conc;
  logic signed [VW-1:0] fr_coef [4];
  logic signed [PW-1:0] fr_prod_rest;

  lbmq5_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_ctl          (in_ctl),
    .dist_in         (dist_in),
    .vel_x           (vel_x),
    .vel_y           (vel_y),
    .edge_kind       (edge_kind),
    .rest_fraction   (rest_fraction),
    .velocity_weight (velocity_weight),
    .inlet_conc      (inlet_conc),
    .outlet_conc     (outlet_conc),
    .out_ctl         (fr_ctl),
    .g_out           (fr_g),
    .conc_out        (fr_conc),
    .coef_out        (fr_coef),
    .prod_rest_out   (fr_prod_rest)
  );

  logic signed [VW-1:0] post [5];

  lbmq5_collide #(.FRAC_BITS(FRAC_BITS)) u_collide (
    .clk          (clk),
    .rst          (rst),
    .in_ctl       (fr_ctl),
    .g_in         (fr_g),
    .conc_in      (fr_conc),
    .coef_in      (fr_coef),
    .prod_rest_in (fr_prod_rest),
    .relax_rate   (relax_rate),
    .done         (done),
    .conc_out     (conc),
    .post_out     (post)
  );

  assign post_rest  = post[0];
  assign post_east  = post[1];
  assign post_north = post[2];
  assign post_west  = post[3];
  assign post_south = post[4];

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##6 done)
    else $error("accepted beat did not come out after 6 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result beat without a matching accepted beat");

  a_wall_bounce: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_wall |-> ##6
      done && conc == '0 && post_rest == '0 && post_east == $past(dist_west, 6)
      && post_north == $past(dist_south, 6))
    else $error("wall beat not bounced back");

  a_inlet_conc: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !is_wall && edge_kind == EDGE_INLET |-> ##6
      conc == $past($signed({1'b0, inlet_conc}), 6))
    else $error("inlet beat lost the set concentration");

endmodule

FILE: tb/lbm_cell_checker.sv
`timescale 1ns / 1ps
module lbm_cell_checker #(
  parameter int FRAC_BITS = lbmq5_pkg::FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 2,
  localparam int RW = FRAC_BITS + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [VW-1:0]              dist_rest,
  input  logic signed [VW-1:0]              dist_east,
  input  logic signed [VW-1:0]              dist_north,
  input  logic signed [VW-1:0]              dist_west,
  input  logic signed [VW-1:0]              dist_south,
  input  logic                              is_wall,
  input  logic signed [VW-1:0]              vel_x,
  input  logic signed [VW-1:0]              vel_y,
  input  logic [1:0]                        edge_kind,
  input  logic                              cfg_wr_en,
  input  logic [lbmq5_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [RW-1:0]                     cfg_data,
  input  logic                              done,
  input  logic signed [VW-1:0]              conc,
  input  logic signed [VW-1:0]              post_rest,
  input  logic signed [VW-1:0]              post_east,
  input  logic signed [VW-1:0]              post_north,
  input  logic signed [VW-1:0]              post_west,
  input  logic signed [VW-1:0]              post_south,
  output int                                pending,
  output int                                fail_count
);
  import lbmq5_pkg::*;

  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint HALF = longint'(1) << (FRAC_BITS - 1);
  localparam longint QMAX = (longint'(1) << (VW - 1)) - 1;
  localparam longint QMIN = -(longint'(1) << (VW - 1));

  // slot 0 holds conc, slots 1..5 hold rest, east, north, west, south
  typedef logic [6*VW-1:0] cell_beat_t;

  logic [RW-1:0] rest_fraction;
  logic [RW-1:0] relax_rate;
  logic [RW-1:0] velocity_weight;
  logic [RW-1:0] inlet_conc;
  logic [RW-1:0] outlet_conc;

  cell_beat_t predicted_cells[$];
  int         queued = 0;
  int         mismatch_total = 0;

  assign pending    = queued;
  assign fail_count = mismatch_total;

  function automatic longint clip(input longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  // round half up, then drop the fraction bits
  function automatic longint round_frac(input longint x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  function automatic string field_label(input int k);
    case (k)
      0:       return "conc";
      1:       return "post_rest";
      2:       return "post_east";
      3:       return "post_north";
      4:       return "post_west";
      default: return "post_south";
    endcase
  endfunction

  function automatic cell_beat_t collide_cell(
    input logic signed [VW-1:0] d_rest, d_east, d_north, d_west, d_south,
    input logic                 wall,
    input logic signed [VW-1:0] vx_in, vy_in,
    input logic [1:0]           kind
  );
    longint     g[5];
    longint     post[5];
    longint     proj[5];
    longint     cc, eq, coef, diff, rf, rr, vw;
    cell_beat_t beat;
    g[0] = d_rest;
    g[1] = d_east;
    g[2] = d_north;
    g[3] = d_west;
    g[4] = d_south;
    rf = longint'(rest_fraction);
    rr = longint'(relax_rate);
    vw = longint'(velocity_weight);
    if (wall) begin
      // bounce back
      cc = 0;
      post[0] = 0;
      post[1] = g[3];
      post[3] = g[1];
      post[2] = g[4];
      post[4] = g[2];
    end else begin
      if (kind == EDGE_INLET) begin
        g[1] = clip(longint'(inlet_conc) - g[0] - g[2] - g[3] - g[4]);
        cc = clip(longint'(inlet_conc));
      end else if (kind == EDGE_OUTLET) begin
        g[3] = clip(longint'(outlet_conc) - g[0] - g[1] - g[2] - g[4]);
        cc = clip(longint'(outlet_conc));
      end else begin
        cc = clip(g[0] + g[1] + g[2] + g[3] + g[4]);
      end
      proj[0] = 0;
      proj[1] = vx_in;
      proj[2] = vy_in;
      proj[3] = -longint'(vx_in);
      proj[4] = -longint'(vy_in);
      for (int k = 0; k < 5; k++) begin
        if (k == 0) begin
          eq = clip(round_frac(cc * rf));
        end else begin
          coef = clip(round_frac((ONE - rf) * (ONE >>> 2) + vw * proj[k]));
          eq = clip(round_frac(cc * coef));
        end
        diff = clip(g[k] - eq);
        post[k] = clip(g[k] - round_frac(rr * diff));
      end
    end
    beat[0 +: VW] = cc[VW-1:0];
    for (int k = 0; k < 5; k++) beat[(k+1)*VW +: VW] = post[k][VW-1:0];
    return beat;
  endfunction

  always @(posedge clk) begin
    cell_beat_t want;
    cell_beat_t got;
    int         nbad;
    nbad = 0;
    if (rst) begin
      rest_fraction   = RW'(13107);
      relax_rate      = RW'(43691);
      velocity_weight = RW'(32768);
      inlet_conc      = RW'(65536);
      outlet_conc     = '0;
      predicted_cells.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REST_FRACTION:   rest_fraction = cfg_data;
          CFG_RELAX_RATE:      relax_rate = cfg_data;
          CFG_VELOCITY_WEIGHT: velocity_weight = cfg_data;
          CFG_INLET_CONC:      inlet_conc = cfg_data;
          CFG_OUTLET_CONC:     outlet_conc = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        predicted_cells.push_back(collide_cell(dist_rest, dist_east, dist_north, dist_west,
                                               dist_south, is_wall, vel_x, vel_y, edge_kind));
      end
      if (done) begin
        got = {post_south, post_west, post_north, post_east, post_rest, conc};
        if (predicted_cells.size() == 0) begin
          $error("result beat with no cell waiting");
          nbad++;
        end else begin
          want = predicted_cells.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (got[k*VW +: VW] !== want[k*VW +: VW]) begin
              $error("%s: expected %0d, got %0d", field_label(k),
                     $signed(want[k*VW +: VW]), $signed(got[k*VW +: VW]));
              nbad++;
            end
          end
        end
      end
    end
    queued <= predicted_cells.size();
    mismatch_total <= mismatch_total + nbad;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lbmq5_pkg::*;

  localparam int FRAC_BITS    = FRAC_BITS_DEF;
  localparam int VW           = FRAC_BITS + 2;
  localparam int RW           = FRAC_BITS + 1;
  localparam int CELL_LATENCY = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_CELLS  = 250;

  localparam logic [1:0] EDGE_UNUSED = 2'd3;

  localparam logic signed [VW-1:0] QMAX   = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] QMIN   = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] QZERO  = '0;
  localparam logic signed [VW-1:0] QNEG1  = '1;
  localparam logic signed [VW-1:0] QONE   = VW'(1 << FRAC_BITS);
  localparam logic signed [VW-1:0] QFIFTH = VW'((1 << FRAC_BITS) / 5);
  localparam logic signed [VW-1:0] QQUART = VW'((1 << FRAC_BITS) / 4);
  localparam logic signed [VW-1:0] QNQUART = -QQUART;

  localparam logic [RW-1:0] REG_MAX = '1;
  localparam logic [RW-1:0] REG_ONE = RW'(1 << FRAC_BITS);

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [VW-1:0] dist_rest, dist_east, dist_north, dist_west, dist_south;
  logic is_wall;
  logic signed [VW-1:0] vel_x, vel_y;
  logic [1:0] edge_kind;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [RW-1:0] cfg_data;
  logic done;
  logic signed [VW-1:0] conc, post_rest, post_east, post_north, post_west, post_south;

  int cells_pending;
  int fail_count;
  int cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lbm_d2q5_cell_update_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .dist_rest(dist_rest), .dist_east(dist_east), .dist_north(dist_north),
    .dist_west(dist_west), .dist_south(dist_south), .is_wall(is_wall),
    .vel_x(vel_x), .vel_y(vel_y), .edge_kind(edge_kind),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .conc(conc), .post_rest(post_rest), .post_east(post_east),
    .post_north(post_north), .post_west(post_west), .post_south(post_south)
  );

  lbm_cell_checker #(.FRAC_BITS(FRAC_BITS)) cell_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .dist_rest(dist_rest), .dist_east(dist_east), .dist_north(dist_north),
    .dist_west(dist_west), .dist_south(dist_south), .is_wall(is_wall),
    .vel_x(vel_x), .vel_y(vel_y), .edge_kind(edge_kind),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .conc(conc), .post_rest(post_rest), .post_east(post_east),
    .post_north(post_north), .post_west(post_west), .post_south(post_south),
    .pending(cells_pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mix of full range, saturation corners and physically sized values
  function automatic logic signed [VW-1:0] draw_value();
    logic signed [VW-1:0] v;
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0, 1: v = VW'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: v = QMAX;
          1: v = QMIN;
          2: v = QZERO;
          3: v = QNEG1;
          default: v = QONE;
        endcase
      end
      default: v = VW'(int'($urandom_range(0, 1 << (FRAC_BITS - 1))) - (1 << (FRAC_BITS - 3)));
    endcase
    return v;
  endfunction

  task automatic send_cell(
    input int                   gap,
    input logic signed [VW-1:0] r, e, n, w, s,
    input logic                 wall,
    input logic signed [VW-1:0] vx, vy,
    input logic [1:0]           kind
  );
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    dist_rest  <= r;
    dist_east  <= e;
    dist_north <= n;
    dist_west  <= w;
    dist_south <= s;
    is_wall    <= wall;
    vel_x      <= vx;
    vel_y      <= vy;
    edge_kind  <= kind;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (cells_pending != 0);
    repeat (CELL_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [RW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [RW-1:0] rf, rr, vw, cin, cout);
    write_reg(CFG_REST_FRACTION, rf);
    write_reg(CFG_RELAX_RATE, rr);
    write_reg(CFG_VELOCITY_WEIGHT, vw);
    write_reg(CFG_INLET_CONC, cin);
    write_reg(CFG_OUTLET_CONC, cout);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int gap;
    bit steady;
    rst        <= 1'b1;
    start      <= 1'b0;
    dist_rest  <= '0;
    dist_east  <= '0;
    dist_north <= '0;
    dist_west  <= '0;
    dist_south <= '0;
    is_wall    <= 1'b0;
    vel_x      <= '0;
    vel_y      <= '0;
    edge_kind  <= EDGE_INTERIOR;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= CFG_REST_FRACTION;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed cells at the reset settings
    send_cell(0, QZERO, QZERO, QZERO, QZERO, QZERO, 1'b0, QZERO, QZERO, EDGE_INTERIOR);
    send_cell(0, QFIFTH, QFIFTH, QFIFTH, QFIFTH, QFIFTH, 1'b0, QZERO, QZERO, EDGE_INTERIOR);
    send_cell(1, QFIFTH, QFIFTH, QFIFTH, QFIFTH, QFIFTH, 1'b0, QQUART, QNQUART,
              EDGE_INTERIOR);
    send_cell(0, QFIFTH, QQUART, QFIFTH, QNQUART, QFIFTH, 1'b0, QQUART, QZERO, EDGE_INLET);
    send_cell(2, QFIFTH, QQUART, QFIFTH, QNQUART, QFIFTH, 1'b0, QZERO, QQUART, EDGE_OUTLET);
    send_cell(0, QFIFTH, QQUART, QFIFTH, QNQUART, QFIFTH, 1'b0, QQUART, QQUART, EDGE_UNUSED);
    send_cell(0, QONE, QQUART, QFIFTH, QNQUART, QNEG1, 1'b1, QQUART, QQUART, EDGE_INTERIOR);
    send_cell(3, QONE, QQUART, QFIFTH, QNQUART, QNEG1, 1'b1, QZERO, QZERO, EDGE_INLET);
    send_cell(0, QONE, QQUART, QFIFTH, QNQUART, QNEG1, 1'b1, QZERO, QZERO, EDGE_OUTLET);
    send_cell(0, QONE, QQUART, QFIFTH, QNQUART, QNEG1, 1'b1, QZERO, QZERO, EDGE_UNUSED);
    send_cell(0, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0, QZERO, QZERO, EDGE_INTERIOR);
    send_cell(1, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0, QZERO, QZERO, EDGE_INTERIOR);
    send_cell(0, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0, QMAX, QMIN, EDGE_INLET);
    send_cell(0, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0, QMIN, QMAX, EDGE_OUTLET);
    send_cell(0, QONE, QONE, QONE, QONE, QONE, 1'b0, QMAX, QMAX, EDGE_INTERIOR);
    send_cell(0, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0, QMIN, QMIN, EDGE_INTERIOR);
    send_cell(0, QMAX, QMIN, QMAX, QMIN, QMAX, 1'b0, QMAX, QMIN, EDGE_UNUSED);
    send_cell(0, QNEG1, QNEG1, QNEG1, QNEG1, QNEG1, 1'b0, QNEG1, QNEG1, EDGE_INTERIOR);
    send_cell(0, QMIN, QMAX, QMIN, QMAX, QMIN, 1'b1, QMAX, QMIN, EDGE_INTERIOR);
    send_cell(0, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0, QZERO, QZERO, EDGE_INLET);
    send_cell(0, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0, QZERO, QZERO, EDGE_OUTLET);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: ;
        1: write_regs('0, '0, '0, '0, '0);
        2: write_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        3: write_regs(REG_ONE, REG_MAX, REG_ONE, '0, REG_ONE);
        default: write_regs(RW'($urandom_range(0, 1 << FRAC_BITS)),
                            RW'($urandom_range(0, (1 << RW) - 1)),
                            RW'($urandom_range(0, 1 << FRAC_BITS)),
                            RW'($urandom_range(0, 1 << FRAC_BITS)),
                            RW'($urandom_range(0, 1 << FRAC_BITS)));
      endcase
      steady = 1'b0;
      for (int n = 0; n < PHASE_CELLS; n++) begin
        // stretches of back-to-back beats between gappy ones
        if (n % 25 == 0) steady = ($urandom_range(0, 2) == 0);
        gap = steady ? 0 : $urandom_range(0, 3);
        send_cell(gap, draw_value(), draw_value(), draw_value(), draw_value(), draw_value(),
                  $urandom_range(0, 3) == 0, draw_value(), draw_value(),
                  2'($urandom_range(0, 3)));
      end
    end
    settle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
